@@ sv/dst_pkg.sv @@
`timescale 1ns / 1ps

package dst_pkg;

	// Phase codes, also driven on the phase field
	typedef enum logic [1:0] {
		MODE_WAIT  = 2'd0,
		MODE_SPIN  = 2'd1,
		MODE_THROW = 2'd2,
		MODE_SLEEP = 2'd3
	} dst_mode_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_IDLE_TIMEOUT = 2'd0,
		CFG_CLICK_BEEP   = 2'd1,
		CFG_FINAL_BEEP   = 2'd2,
		CFG_STOP_BASE    = 2'd3
	} dst_cfg_idx_t;

	localparam int DIV_W   = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [15:0] SEED_RESET      = 16'd1000;
	localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10000;
	localparam logic [4:0]  CLICK_BEEP_RST  = 5'd3;
	localparam logic [4:0]  FINAL_BEEP_RST  = 5'd20;
	localparam logic [8:0]  STOP_BASE_RST   = 9'd250;
	localparam logic [2:0]  FACE_COUNT      = 3'd6;
	localparam logic [10:0] START_DELAY     = 11'd68;
	localparam logic [15:0] HOLD_CAP        = 16'd1023;
	localparam logic [4:0]  BEEP_MAX        = 5'd31;

	typedef struct packed {
		logic [15:0] idle_timeout;
		logic [4:0]  click_beep_ticks;
		logic [4:0]  final_beep_ticks;
		logic [8:0]  stop_base;
	} dst_cfg_t;

	typedef struct packed {
		logic [6:0] led_pattern;
		logic       beeper;
		logic       sleeping;
		logic [1:0] phase;
	} dst_result_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [2:0]       divisor;
	} dst_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} dst_div_rsp_t;

	function automatic logic [6:0] face_dots(input logic [2:0] idx);
		logic [6:0] d;
		case (idx)
			3'd0:    d = 7'h08;
			3'd1:    d = 7'h41;
			3'd2:    d = 7'h2A;
			3'd3:    d = 7'h63;
			3'd4:    d = 7'h6B;
			3'd5:    d = 7'h77;
			default: d = 7'h08;
		endcase
		return d;
	endfunction

	function automatic logic [6:0] spin_dots(input logic [2:0] idx);
		logic [6:0] d;
		case (idx)
			3'd0:    d = 7'h03;
			3'd1:    d = 7'h12;
			3'd2:    d = 7'h50;
			3'd3:    d = 7'h60;
			3'd4:    d = 7'h24;
			3'd5:    d = 7'h05;
			default: d = 7'h03;
		endcase
		return d;
	endfunction

	// Remainder by six: fold base-4 digits for the remainder by three, then pick
	// the one of r and r + 3 whose parity matches the low bit
	function automatic logic [2:0] mod6(input logic [15:0] x);
		logic [4:0] s;
		logic [2:0] t;
		logic [2:0] u;
		logic [2:0] r3;
		s = '0;
		for (int i = 0; i < 8; i++)
			s = s + {3'd0, x[2*i +: 2]};
		t  = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'd0, s[4]};
		u  = {1'b0, t[1:0]} + {2'd0, t[2]};
		r3 = (u >= 3'd3) ? u - 3'd3 : u;
		return (r3[0] == x[0]) ? r3 : r3 + 3'd3;
	endfunction

endpackage

@@ sv/dst_if.sv @@
`timescale 1ns / 1ps

interface dst_tick_if;
	logic valid;
	logic ready;
	logic button;
	modport source (output valid, output button, input ready);
	modport sink   (input valid, input button, output ready);
endinterface

interface dst_res_if;
	logic       valid;
	logic       ready;
	logic [6:0] led_pattern;
	logic       beeper;
	logic       sleeping;
	logic [1:0] phase;
	modport source (output valid, output led_pattern, output beeper, output sleeping,
		output phase, input ready);
	modport sink   (input valid, input led_pattern, input beeper, input sleeping,
		input phase, output ready);
endinterface

interface dst_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/dst_div.sv @@
`timescale 1ns / 1ps

module dst_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dst_pkg::dst_div_req_t req,
	output dst_pkg::dst_div_rsp_t rsp
);
	import dst_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     num_q;
	logic [2:0]           rem_q;
	logic [2:0]           den_q;

	logic [3:0] trial;
	logic       ge;
	logic [3:0] trial_sub;

	// one quotient bit per cycle, restoring
	assign trial     = {rem_q, num_q[DIV_W-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], ge};
			rem_q <= ge ? trial_sub[2:0] : trial[2:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

@@ sv/dst_ctrl.sv @@
`timescale 1ns / 1ps

module dst_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dst_pkg::dst_cfg_t     cfg,
	input  logic                  in_valid,
	input  logic                  button,
	output logic                  in_ready,
	output logic                  res_valid,
	input  logic                  res_room,
	output dst_pkg::dst_result_t  res,
	output dst_pkg::dst_div_req_t div_req,
	input  dst_pkg::dst_div_rsp_t div_rsp
);
	import dst_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_STEP_DIV,
		ST_OUT
	} state_t;

	state_t      state_q;
	dst_mode_t   mode_q;
	logic [15:0] seed_q;
	logic [15:0] last_seed_q;
	logic [15:0] idle_q;
	logic [2:0]  face_q;
	logic [10:0] step_q;
	logic [9:0]  stop_q;
	logic [2:0]  slow_q;
	logic [10:0] wait_q;
	logic [4:0]  beep_q;
	logic [6:0]  shown_q;
	logic              div_start_q;
	logic [DIV_W-1:0]  div_num_q;
	logic [2:0]        div_den_q;

	logic [2:0]  face_mod;
	logic [2:0]  face_next;
	logic [10:0] wait_next;
	logic [15:0] idle_next;
	logic [15:0] hold_raw;
	logic [5:0]  hold_div16;
	logic [5:0]  beep_sum;
	logic [10:0] step_next;

	assign face_mod   = (face_q >= FACE_COUNT) ? face_q - FACE_COUNT : face_q;
	assign face_next  = (face_mod == FACE_COUNT - 3'd1) ? 3'd0 : face_mod + 3'd1;
	assign wait_next  = (wait_q != '0) ? wait_q - 11'd1 : wait_q;
	assign idle_next  = idle_q + 16'd1;
	assign hold_raw   = seed_q - last_seed_q;
	assign hold_div16 = (hold_raw > HOLD_CAP) ? HOLD_CAP[9:4] : hold_raw[9:4];
	assign beep_sum   = {1'b0, beep_q} + {1'b0, cfg.final_beep_ticks};
	assign step_next  = step_q + 11'd3 + div_rsp.quot[10:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_WAIT;
			seed_q      <= SEED_RESET;
			last_seed_q <= '0;
			idle_q      <= '0;
			face_q      <= '0;
			step_q      <= '0;
			stop_q      <= '0;
			slow_q      <= 3'd1;
			wait_q      <= '0;
			beep_q      <= '0;
			shown_q     <= '0;
			div_start_q <= 1'b0;
			div_num_q   <= '0;
			div_den_q   <= 3'd1;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (button) begin
							if (mode_q == MODE_THROW)
								last_seed_q <= seed_q;
							shown_q <= spin_dots(mod6({5'd0, seed_q[15:5]}));
							seed_q  <= seed_q + 16'd1;
							mode_q  <= MODE_SPIN;
							idle_q  <= '0;
							state_q <= ST_OUT;
						end else begin
							case (mode_q)
								MODE_SPIN: begin
									face_q  <= mod6(seed_q);
									stop_q  <= {1'b0, cfg.stop_base} + {1'b0, seed_q[6:0], 2'b00};
									step_q  <= START_DELAY - {5'd0, hold_div16};
									slow_q  <= mod6({2'd0, seed_q[15:2]}) + 3'd1;
									mode_q  <= MODE_THROW;
									state_q <= ST_STEP;
								end
								MODE_THROW: begin
									wait_q <= wait_next;
									if (wait_next == '0) begin
										shown_q <= face_dots(face_mod);
										beep_q  <= cfg.click_beep_ticks;
										face_q  <= face_next;
										state_q <= ST_STEP;
									end else begin
										state_q <= ST_OUT;
									end
								end
								MODE_WAIT: begin
									if (idle_next >= cfg.idle_timeout) begin
										shown_q <= '0;
										beep_q  <= '0;
										idle_q  <= '0;
										mode_q  <= MODE_SLEEP;
									end else begin
										idle_q <= idle_next;
									end
									state_q <= ST_OUT;
								end
								default: begin
									shown_q <= '0;
									state_q <= ST_OUT;
								end
							endcase
						end
					end
				end
				ST_STEP: begin
					if (step_q < {1'b0, stop_q}) begin
						div_start_q <= 1'b1;
						div_num_q   <= {5'd0, step_q};
						div_den_q   <= (slow_q == '0) ? 3'd1 : slow_q;
						state_q     <= ST_STEP_DIV;
					end else begin
						// throw over: long beep, back to waiting
						beep_q      <= (beep_sum > {1'b0, BEEP_MAX}) ? BEEP_MAX : beep_sum[4:0];
						last_seed_q <= seed_q;
						idle_q      <= '0;
						mode_q      <= MODE_WAIT;
						state_q     <= ST_OUT;
					end
				end
				ST_STEP_DIV: begin
					if (div_rsp.done) begin
						step_q  <= step_next;
						wait_q  <= step_next;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register frees up
					if (res_room) begin
						if (beep_q != '0)
							beep_q <= beep_q - 5'd1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign res_valid       = (state_q == ST_OUT);
	assign res.led_pattern = shown_q;
	assign res.beeper      = (beep_q != '0);
	assign res.sleeping    = (mode_q == MODE_SLEEP);
	assign res.phase       = mode_q;

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_num_q;
	assign div_req.divisor  = div_den_q;

endmodule

@@ sv/dice_spin_throw_controller.sv @@
`timescale 1ns / 1ps

// channel   dir  payload                                   accepted when
// tick      in   button                                    tick.valid & tick.ready
// result    out  led_pattern, beeper, sleeping, phase      result.valid & result.ready
// cfg       in   index (2 b), data (16 b)                  cfg.valid & cfg.ready
//
// One tick word at a time. The release tick and a throw tick that loads a new delay
// go through the step state and one pass of the 16-step divider over the slowdown
// divisor. A tick ending a throw only passes the step state; other ticks skip it.
// The result register lets the next tick in while a result word is still pending;
// a full register that is not being read holds the block in its output state.
// arst_n resets all but the result and divider data registers; cfg is always ready.
module dice_spin_throw_controller (
	input logic      clk,
	input logic      arst_n,
	dst_tick_if.sink  tick,
	dst_res_if.source result,
	dst_cfg_if.sink   cfg
);
	import dst_pkg::*;

	dst_cfg_t     cfg_q;
	dst_result_t  res_c;
	dst_result_t  out_q;
	logic         out_valid_q;
	logic         res_valid;
	logic         res_room;
	dst_div_req_t div_req;
	dst_div_rsp_t div_rsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_timeout     <= IDLE_TIMEOUT_RST;
			cfg_q.click_beep_ticks <= CLICK_BEEP_RST;
			cfg_q.final_beep_ticks <= FINAL_BEEP_RST;
			cfg_q.stop_base        <= STOP_BASE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_IDLE_TIMEOUT: cfg_q.idle_timeout     <= cfg.data;
				CFG_CLICK_BEEP:   cfg_q.click_beep_ticks <= cfg.data[4:0];
				CFG_FINAL_BEEP:   cfg_q.final_beep_ticks <= cfg.data[4:0];
				CFG_STOP_BASE:    cfg_q.stop_base        <= cfg.data[8:0];
				default: ;
			endcase
		end
	end

	assign res_room = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_room) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_room)
			out_q <= res_c;
	end

	assign result.valid       = out_valid_q;
	assign result.led_pattern = out_q.led_pattern;
	assign result.beeper      = out_q.beeper;
	assign result.sleeping    = out_q.sleeping;
	assign result.phase       = out_q.phase;

	dst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (tick.valid),
		.button    (tick.button),
		.in_ready  (tick.ready),
		.res_valid (res_valid),
		.res_room  (res_room),
		.res       (res_c),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	dst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

@@ tb/tb_dice_spin_throw_controller.sv @@
`timescale 1ns / 1ps

module tb_dice_spin_throw_controller;
	import dst_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_TICKS = 850;

	typedef struct packed {
		bit           is_reg;
		dst_cfg_idx_t reg_idx;
		logic [15:0]  reg_val;
		logic         button;
		bit           typed;
		dst_result_t  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dst_tick_if tick_bus ();
	dst_res_if  display_bus ();
	dst_cfg_if  reg_bus ();

	dice_spin_throw_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus),
		.result (display_bus),
		.cfg    (reg_bus)
	);

	always #5 clk = ~clk;

	// Predicted die state and register copy
	dst_cfg_t    regs;
	dst_mode_t   mode_q;
	logic [15:0] seed_q;
	logic [15:0] last_seed_q;
	logic [15:0] idle_q;
	logic [2:0]  face_q;
	logic [10:0] delay_q;
	logic [9:0]  limit_q;
	logic [2:0]  slow_q;
	logic [10:0] wait_q;
	logic [4:0]  beep_q;
	logic [6:0]  dots_q;

	dst_result_t due_displays[$];
	int          errors = 0;
	int          ticks_sent = 0;
	int          cycle_cnt = 0;
	bit          calm = 1'b0;

	function automatic logic [6:0] die_dots(input bit spinning, input logic [2:0] idx);
		logic [6:0] d;
		if (spinning) begin
			case (idx)
				3'd0:    d = 7'h03;
				3'd1:    d = 7'h12;
				3'd2:    d = 7'h50;
				3'd3:    d = 7'h60;
				3'd4:    d = 7'h24;
				default: d = 7'h05;
			endcase
		end else begin
			case (idx)
				3'd0:    d = 7'h08;
				3'd1:    d = 7'h41;
				3'd2:    d = 7'h2A;
				3'd3:    d = 7'h63;
				3'd4:    d = 7'h6B;
				default: d = 7'h77;
			endcase
		end
		return d;
	endfunction

	// Grow the face interval, or end the throw once it reaches the stop limit
	function automatic void step_throw();
		logic [10:0] q;
		if (delay_q < 11'(limit_q)) begin
			q = (slow_q == 3'd0) ? 11'd1 : 11'(slow_q);
			delay_q = delay_q + 11'd3 + delay_q / q;
			wait_q = delay_q;
		end else begin
			if (int'(beep_q) + int'(regs.final_beep_ticks) > 31)
				beep_q = 5'd31;
			else
				beep_q = beep_q + regs.final_beep_ticks;
			last_seed_q = seed_q;
			idle_q = '0;
			mode_q = MODE_WAIT;
		end
	endfunction

	function automatic dst_result_t advance_dice(input logic pressed);
		dst_result_t shown;
		logic [15:0] hold;
		if (pressed) begin
			if (mode_q == MODE_THROW)
				last_seed_q = seed_q;
			mode_q = MODE_SPIN;
			idle_q = '0;
			dots_q = die_dots(1'b1, 3'((seed_q / 16'd32) % 16'd6));
			seed_q = seed_q + 16'd1;
		end else if (mode_q == MODE_SPIN) begin
			hold = seed_q - last_seed_q;
			if (hold > 16'd1023)
				hold = 16'd1023;
			face_q = 3'(seed_q % 16'd6);
			limit_q = 10'(int'(regs.stop_base) + int'(seed_q % 16'd128) * 4);
			slow_q = 3'(1 + int'((seed_q / 16'd4) % 16'd6));
			delay_q = 11'(68 - int'(hold / 16'd16));
			mode_q = MODE_THROW;
			step_throw();
		end else if (mode_q == MODE_THROW) begin
			if (wait_q != '0)
				wait_q = wait_q - 11'd1;
			if (wait_q == '0) begin
				face_q = face_q % 3'd6;
				dots_q = die_dots(1'b0, face_q);
				beep_q = regs.click_beep_ticks;
				face_q = (face_q == 3'd5) ? 3'd0 : face_q + 3'd1;
				step_throw();
			end
		end else if (mode_q == MODE_WAIT) begin
			idle_q = idle_q + 16'd1;
			if (idle_q >= regs.idle_timeout) begin
				dots_q = '0;
				beep_q = '0;
				idle_q = '0;
				mode_q = MODE_SLEEP;
			end
		end else begin
			dots_q = '0;
		end
		shown.led_pattern = dots_q;
		shown.beeper = (beep_q != '0);
		shown.sleeping = (mode_q == MODE_SLEEP);
		shown.phase = mode_q;
		if (beep_q != '0)
			beep_q = beep_q - 5'd1;
		return shown;
	endfunction

	// Some stretches of the run go without any idling
	function automatic bit steady_band();
		return (ticks_sent % 300) < 60;
	endfunction

	function automatic dir_row_t tick_row(input logic b, input bit typed, input dst_result_t want);
		return '{1'b0, CFG_IDLE_TIMEOUT, 16'd0, b, typed, want};
	endfunction

	function automatic dir_row_t reg_row(input dst_cfg_idx_t idx, input logic [15:0] val);
		return '{1'b1, idx, val, 1'b0, 1'b0, '0};
	endfunction

	task automatic send_tick(input logic b, input bit typed, input dst_result_t want);
		dst_result_t got;
		@(negedge clk);
		if (!calm && !steady_band() && $urandom_range(0, 99) < 20) begin
			tick_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.button <= b;
		do @(posedge clk); while (!tick_bus.ready);
		got = advance_dice(b);
		due_displays.push_back(typed ? want : got);
		ticks_sent++;
	endtask

	// Drain every pending display word before touching a register
	task automatic write_reg(input dst_cfg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		tick_bus.valid <= 1'b0;
		while (due_displays.size() != 0) @(negedge clk);
		reg_bus.valid <= 1'b1;
		reg_bus.index <= idx;
		reg_bus.data <= val;
		do @(posedge clk); while (!reg_bus.ready);
		case (idx)
			CFG_IDLE_TIMEOUT: regs.idle_timeout = val;
			CFG_CLICK_BEEP:   regs.click_beep_ticks = val[4:0];
			CFG_FINAL_BEEP:   regs.final_beep_ticks = val[4:0];
			default:          regs.stop_base = val[8:0];
		endcase
		@(negedge clk);
		reg_bus.valid <= 1'b0;
	endtask

	initial begin : sink_side
		int stall;
		display_bus.ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall == 0 && !calm && !steady_band() && $urandom_range(0, 99) < 20)
				stall = $urandom_range(1, 7);
			if (stall != 0) begin
				display_bus.ready <= 1'b0;
				stall--;
			end else begin
				display_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		dst_result_t want;
		if (arst_n && display_bus.valid && display_bus.ready) begin
			if (due_displays.size() == 0) begin
				$display("%0t: display word with none expected: led %h beep %b sleep %b phase %0d",
					$time, display_bus.led_pattern, display_bus.beeper, display_bus.sleeping,
					display_bus.phase);
				errors++;
			end else begin
				want = due_displays.pop_front();
				if (display_bus.led_pattern !== want.led_pattern) begin
					$display("%0t: led_pattern expected %h got %h", $time, want.led_pattern,
						display_bus.led_pattern);
					errors++;
				end
				if (display_bus.beeper !== want.beeper) begin
					$display("%0t: beeper expected %b got %b", $time, want.beeper,
						display_bus.beeper);
					errors++;
				end
				if (display_bus.sleeping !== want.sleeping) begin
					$display("%0t: sleeping expected %b got %b", $time, want.sleeping,
						display_bus.sleeping);
					errors++;
				end
				if (display_bus.phase !== want.phase) begin
					$display("%0t: phase expected %0d got %0d", $time, want.phase,
						display_bus.phase);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d display words pending", $time,
				due_displays.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		dir_row_t    script[$];
		int          kind;
		int          n;
		int          span;
		int          k;
		logic [15:0] v;

		tick_bus.valid = 1'b0;
		tick_bus.button = 1'b0;
		reg_bus.valid = 1'b0;
		reg_bus.index = CFG_IDLE_TIMEOUT;
		reg_bus.data = '0;

		regs.idle_timeout = IDLE_TIMEOUT_RST;
		regs.click_beep_ticks = CLICK_BEEP_RST;
		regs.final_beep_ticks = FINAL_BEEP_RST;
		regs.stop_base = STOP_BASE_RST;
		mode_q = MODE_WAIT;
		seed_q = SEED_RESET;
		last_seed_q = '0;
		idle_q = '0;
		face_q = '0;
		delay_q = '0;
		limit_q = '0;
		slow_q = 3'd1;
		wait_q = '0;
		beep_q = '0;
		dots_q = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Idle tick, instant sleep, spin out of sleep, release, first face, cut throw
		script.push_back(tick_row(1'b0, 1'b1, {7'h00, 1'b0, 1'b0, MODE_WAIT}));
		script.push_back(reg_row(CFG_IDLE_TIMEOUT, 16'd0));
		script.push_back(tick_row(1'b0, 1'b1, {7'h00, 1'b0, 1'b1, MODE_SLEEP}));
		script.push_back(tick_row(1'b0, 1'b1, {7'h00, 1'b0, 1'b1, MODE_SLEEP}));
		script.push_back(reg_row(CFG_STOP_BASE, 16'd511));
		script.push_back(reg_row(CFG_CLICK_BEEP, 16'd31));
		script.push_back(tick_row(1'b1, 1'b1, {7'h12, 1'b0, 1'b0, MODE_SPIN}));
		script.push_back(tick_row(1'b1, 1'b0, '0));
		for (int i = 0; i < 11; i++)
			script.push_back(tick_row(1'b0, 1'b0, '0));
		script.push_back(tick_row(1'b1, 1'b0, '0));
		script.push_back(tick_row(1'b0, 1'b0, '0));
		script.push_back(reg_row(CFG_FINAL_BEEP, 16'd31));
		script.push_back(reg_row(CFG_IDLE_TIMEOUT, 16'd65535));
		script.push_back(reg_row(CFG_CLICK_BEEP, 16'd0));
		script.push_back(reg_row(CFG_STOP_BASE, 16'd0));

		foreach (script[i]) begin
			if (script[i].is_reg)
				write_reg(script[i].reg_idx, script[i].reg_val);
			else
				send_tick(script[i].button, script[i].typed, script[i].want);
		end

		while (ticks_sent < RANDOM_TICKS + 20) begin
			if (ticks_sent > RANDOM_TICKS - 80)
				calm = 1'b1;

			if ($urandom_range(0, 2) == 0) begin
				for (int i = 0; i < 4; i++) begin
					if ($urandom_range(0, 1) == 0)
						continue;
					case (dst_cfg_idx_t'(i))
						CFG_IDLE_TIMEOUT: begin
							k = $urandom_range(0, 9);
							if (k == 0)
								v = 16'd0;
							else if (k == 1)
								v = 16'hFFFF;
							else if (k == 2)
								v = 16'($urandom_range(0, 65535));
							else
								v = 16'($urandom_range(1, 40));
						end
						CFG_STOP_BASE: begin
							k = $urandom_range(0, 9);
							if (k < 7)
								v = 16'($urandom_range(0, 40));
							else if (k == 7)
								v = 16'd511;
							else
								v = 16'($urandom_range(0, 511));
							// junk above the register width
							v = v | (16'($urandom_range(0, 127)) << 9);
						end
						default: begin
							k = $urandom_range(0, 5);
							v = (k == 0) ? 16'd0 : (k == 1) ? 16'd31 : 16'($urandom_range(0, 31));
							v = v | (16'($urandom_range(0, 2047)) << 5);
						end
					endcase
					write_reg(dst_cfg_idx_t'(i), v);
				end
			end

			// Complete rounds steer the seed so the stop limit stays low
			kind = $urandom_range(0, 9);
			if (kind < 4 && regs.stop_base <= 9'd40) begin
				n = ($urandom_range(0, 8) - int'(seed_q % 16'd128) + 128) % 128;
				if (n == 0)
					n = 128;
			end else begin
				n = $urandom_range(1, 24);
			end
			repeat (n) send_tick(1'b1, 1'b0, '0);

			span = (kind < 4) ? 400 : $urandom_range(0, 120);
			k = 0;
			while ((mode_q == MODE_SPIN || mode_q == MODE_THROW) && k < span) begin
				send_tick((kind >= 4 && $urandom_range(0, 99) < 4) ? 1'b1 : 1'b0, 1'b0, '0);
				k++;
			end

			if (regs.idle_timeout != '0 && regs.idle_timeout <= 16'd60 && $urandom_range(0, 1))
				span = int'(regs.idle_timeout) + $urandom_range(0, 4);
			else
				span = $urandom_range(0, 8);
			repeat (span) send_tick(1'b0, 1'b0, '0);
		end

		@(negedge clk);
		tick_bus.valid <= 1'b0;
		while (due_displays.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ dice_spin_throw_controller.f @@
sv/dst_pkg.sv
sv/dst_if.sv
sv/dst_div.sv
sv/dst_ctrl.sv
sv/dice_spin_throw_controller.sv
tb/tb_dice_spin_throw_controller.sv
